[design/pcsf_pkg.sv]
// Shared types, constants and helpers for the phase current sense filter.
`timescale 1ns / 1ps
`default_nettype none
package pcsf_pkg;

  // Default ADC resolution
  localparam int ADC_BITS_DEF = 12;

  // Digit-serial multiplier geometry
  localparam int DIGIT_W  = 8;
  localparam int DIGITS   = 3;
  localparam int MPLIER_W = DIGIT_W * DIGITS;
  localparam int MCAND_W  = 34;
  localparam int ACC_W    = MCAND_W + 1;
  localparam int SUM_W    = MCAND_W + DIGIT_W + 1;
  localparam int PROD_W   = ACC_W + MPLIER_W;

  // Fixed-point shifts
  localparam int VOLT_SHIFT = 8;
  localparam int VOLT_W     = 32;
  localparam int Q_SHIFT    = 16;
  localparam int DELTA_W    = 35;

  // Register widths
  localparam int CFG_W     = 24;
  localparam int SCALE_W   = 24;
  localparam int OFFSET_W  = 19;
  localparam int ALPHA_W   = 17;
  localparam int CURRENT_W = 32;

  // Register reset values
  localparam logic [SCALE_W-1:0]         ADC_TO_VOLT_RST   = 24'd13517;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST        = 19'sd108134;
  localparam logic [SCALE_W-1:0]         AMPS_PER_VOLT_RST = 24'd3276800;
  localparam logic [ALPHA_W-1:0]         FILTER_ALPHA_RST  = 17'd6554;
  localparam logic [ALPHA_W-1:0]         ALPHA_ONE         = 17'd65536;

  typedef enum logic [2:0] {
    CFG_ADC_TO_VOLT   = 3'd0,
    CFG_OFFSET_A      = 3'd1,
    CFG_OFFSET_B      = 3'd2,
    CFG_AMPS_PER_VOLT = 3'd3,
    CFG_FILTER_ALPHA  = 3'd4
  } pcsf_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOLT,
    ST_LD_AMP,
    ST_AMP,
    ST_LD_FILT,
    ST_FILT,
    ST_COMMIT,
    ST_DONE
  } pcsf_state_t;

  typedef enum logic [1:0] {
    PH_VOLT,
    PH_AMP,
    PH_FILT
  } pcsf_phase_t;

  typedef struct packed {
    logic        load;
    pcsf_phase_t phase;
    logic        step;
    logic        commit;
  } pcsf_ctrl_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [CURRENT_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = SUM_W'(32'sh8000_0000);
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[CURRENT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[design/pcsf_chan.sv]
// One phase: volts, offset, amp scaling and low-pass on a digit-serial multiplier.
`timescale 1ns / 1ps
`default_nettype none
module pcsf_chan #(
  parameter int ADC_BITS = pcsf_pkg::ADC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire pcsf_pkg::pcsf_ctrl_t                  ctrl,
  input  wire logic [ADC_BITS-1:0]                   sample,
  input  wire logic [pcsf_pkg::SCALE_W-1:0]          adc_to_volt,
  input  wire logic signed [pcsf_pkg::OFFSET_W-1:0]  offset,
  input  wire logic [pcsf_pkg::SCALE_W-1:0]          amps_per_volt,
  input  wire logic [pcsf_pkg::ALPHA_W-1:0]          alpha,
  output logic signed [pcsf_pkg::CURRENT_W-1:0]      filt
);

  logic signed [pcsf_pkg::MCAND_W-1:0]   mcand_r, mcand_nxt;
  logic [pcsf_pkg::MPLIER_W-1:0]         mplier_r, mplier_nxt;
  logic signed [pcsf_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [pcsf_pkg::MPLIER_W-1:0]         low_r, low_nxt;
  logic signed [pcsf_pkg::CURRENT_W-1:0] filt_r, filt_nxt;

  logic [pcsf_pkg::PROD_W-1:0]           prod;
  logic signed [pcsf_pkg::SUM_W-1:0]     pp;
  logic signed [pcsf_pkg::SUM_W-1:0]     sum;
  logic [pcsf_pkg::VOLT_W-1:0]           volts;
  logic signed [pcsf_pkg::MCAND_W-1:0]   diff;
  logic signed [pcsf_pkg::CURRENT_W-1:0] raw;
  logic signed [pcsf_pkg::CURRENT_W:0]   err;
  logic [pcsf_pkg::ALPHA_W-1:0]          alpha_eff;
  logic signed [pcsf_pkg::DELTA_W-1:0]   delta;
  logic signed [pcsf_pkg::SUM_W-1:0]     filt_sum;

  // Full product once all digits are in: high part in acc_r, low digits in low_r
  assign prod  = {acc_r, low_r};
  assign pp    = mcand_r * $signed({1'b0, mplier_r[pcsf_pkg::DIGIT_W-1:0]});
  assign sum   = pcsf_pkg::SUM_W'(acc_r) + pp;

  assign volts = prod[pcsf_pkg::VOLT_SHIFT +: pcsf_pkg::VOLT_W];
  assign diff  = $signed({2'b00, volts}) - pcsf_pkg::MCAND_W'(offset);
  assign raw   = pcsf_pkg::sat32($signed(prod[pcsf_pkg::PROD_W-1:pcsf_pkg::Q_SHIFT]));
  assign err   = (pcsf_pkg::CURRENT_W+1)'(raw) - (pcsf_pkg::CURRENT_W+1)'(filt_r);
  assign alpha_eff = (alpha > pcsf_pkg::ALPHA_ONE) ? pcsf_pkg::ALPHA_ONE : alpha;
  assign delta = $signed(prod[pcsf_pkg::Q_SHIFT +: pcsf_pkg::DELTA_W]);
  assign filt_sum = pcsf_pkg::SUM_W'(filt_r) + pcsf_pkg::SUM_W'(delta);

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    low_nxt    = low_r;
    filt_nxt   = filt_r;
    if (ctrl.load) begin
      acc_nxt = '0;
      case (ctrl.phase)
        pcsf_pkg::PH_VOLT: begin
          mcand_nxt  = $signed({{(pcsf_pkg::MCAND_W-pcsf_pkg::SCALE_W){1'b0}}, adc_to_volt});
          mplier_nxt = pcsf_pkg::MPLIER_W'(sample);
        end
        pcsf_pkg::PH_AMP: begin
          mcand_nxt  = diff;
          mplier_nxt = amps_per_volt;
        end
        pcsf_pkg::PH_FILT: begin
          mcand_nxt  = pcsf_pkg::MCAND_W'(err);
          mplier_nxt = pcsf_pkg::MPLIER_W'(alpha_eff);
        end
        default: begin
          mcand_nxt = mcand_r;
        end
      endcase
    end else if (ctrl.step) begin
      // Add one digit's partial product, shift the settled low digit out
      acc_nxt    = sum[pcsf_pkg::SUM_W-1:pcsf_pkg::DIGIT_W];
      low_nxt    = {sum[pcsf_pkg::DIGIT_W-1:0],
                    low_r[pcsf_pkg::MPLIER_W-1:pcsf_pkg::DIGIT_W]};
      mplier_nxt = mplier_r >> pcsf_pkg::DIGIT_W;
    end
    if (ctrl.commit) begin
      filt_nxt = pcsf_pkg::sat32(filt_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else begin
      filt_r <= filt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    low_r    <= low_nxt;
  end

  assign filt = filt_r;

endmodule
`default_nettype wire

[design/phase_current_sense_filter.sv]
// Phase current sense filter: two phases in lockstep, each on an 8-bit-digit multiplier.
// A new pair is taken only in idle: after three 3-digit products per phase on the shared
// shift-and-add multiplier of each channel, plus load and commit steps, and after the
// result is loaded into the output register; a full, stalled register delays that load.
// A finished result waits in the output register while the next pair is taken.
// Reset (synchronous, rst_n low) clears both filter states and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module phase_current_sense_filter #(
  parameter int ADC_BITS = pcsf_pkg::ADC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [ADC_BITS-1:0]                   in_sample_a,
  input  wire logic [ADC_BITS-1:0]                   in_sample_b,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [pcsf_pkg::CURRENT_W-1:0]      out_current_a,
  output logic signed [pcsf_pkg::CURRENT_W-1:0]      out_current_b,
  input  wire logic                                  cfg_we,
  input  wire logic [2:0]                            cfg_index,
  input  wire logic [pcsf_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int CNT_W = $clog2(pcsf_pkg::DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pcsf_pkg::DIGITS - 1);

  pcsf_pkg::pcsf_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  pcsf_pkg::pcsf_ctrl_t  ctrl;
  logic                  out_load;

  logic [pcsf_pkg::SCALE_W-1:0]          adc_to_volt_r;
  logic signed [pcsf_pkg::OFFSET_W-1:0]  offset_a_r;
  logic signed [pcsf_pkg::OFFSET_W-1:0]  offset_b_r;
  logic [pcsf_pkg::SCALE_W-1:0]          amps_per_volt_r;
  logic [pcsf_pkg::ALPHA_W-1:0]          filter_alpha_r;

  logic                                  out_valid_r, out_valid_nxt;
  logic signed [pcsf_pkg::CURRENT_W-1:0] out_current_a_r, out_current_b_r;
  logic signed [pcsf_pkg::CURRENT_W-1:0] filt_a, filt_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_to_volt_r   <= pcsf_pkg::ADC_TO_VOLT_RST;
      offset_a_r      <= pcsf_pkg::OFFSET_RST;
      offset_b_r      <= pcsf_pkg::OFFSET_RST;
      amps_per_volt_r <= pcsf_pkg::AMPS_PER_VOLT_RST;
      filter_alpha_r  <= pcsf_pkg::FILTER_ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcsf_pkg::CFG_ADC_TO_VOLT:   adc_to_volt_r   <= cfg_wdata;
        pcsf_pkg::CFG_OFFSET_A:      offset_a_r      <= cfg_wdata[pcsf_pkg::OFFSET_W-1:0];
        pcsf_pkg::CFG_OFFSET_B:      offset_b_r      <= cfg_wdata[pcsf_pkg::OFFSET_W-1:0];
        pcsf_pkg::CFG_AMPS_PER_VOLT: amps_per_volt_r <= cfg_wdata;
        pcsf_pkg::CFG_FILTER_ALPHA:  filter_alpha_r  <= cfg_wdata[pcsf_pkg::ALPHA_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    out_load  = 1'b0;
    case (state_r)
      pcsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          ctrl.phase = pcsf_pkg::PH_VOLT;
          cnt_nxt    = '0;
          state_nxt  = pcsf_pkg::ST_VOLT;
        end
      end
      pcsf_pkg::ST_VOLT: begin
        ctrl.step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = pcsf_pkg::ST_LD_AMP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pcsf_pkg::ST_LD_AMP: begin
        ctrl.load  = 1'b1;
        ctrl.phase = pcsf_pkg::PH_AMP;
        state_nxt  = pcsf_pkg::ST_AMP;
      end
      pcsf_pkg::ST_AMP: begin
        ctrl.step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = pcsf_pkg::ST_LD_FILT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pcsf_pkg::ST_LD_FILT: begin
        ctrl.load  = 1'b1;
        ctrl.phase = pcsf_pkg::PH_FILT;
        state_nxt  = pcsf_pkg::ST_FILT;
      end
      pcsf_pkg::ST_FILT: begin
        ctrl.step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = pcsf_pkg::ST_COMMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pcsf_pkg::ST_COMMIT: begin
        ctrl.commit = 1'b1;
        state_nxt   = pcsf_pkg::ST_DONE;
      end
      pcsf_pkg::ST_DONE: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = pcsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcsf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_current_a_r <= filt_a;
      out_current_b_r <= filt_b;
    end
  end

  pcsf_chan #(
    .ADC_BITS (ADC_BITS)
  ) u_chan_a (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .sample        (in_sample_a),
    .adc_to_volt   (adc_to_volt_r),
    .offset        (offset_a_r),
    .amps_per_volt (amps_per_volt_r),
    .alpha         (filter_alpha_r),
    .filt          (filt_a)
  );

  pcsf_chan #(
    .ADC_BITS (ADC_BITS)
  ) u_chan_b (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .sample        (in_sample_b),
    .adc_to_volt   (adc_to_volt_r),
    .offset        (offset_b_r),
    .amps_per_volt (amps_per_volt_r),
    .alpha         (filter_alpha_r),
    .filt          (filt_b)
  );

  assign in_stall      = (state_r != pcsf_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_current_a = out_current_a_r;
  assign out_current_b = out_current_b_r;

endmodule
`default_nettype wire
